// ===== src/fadp_pkg.sv =====
// Shared types and constants for the framed ASCII decimal parser.
// No dependencies; used by every module under src.
`timescale 1ns / 1ps
`default_nettype none
package fadp_pkg;

	localparam int MANT_W = 56;
	localparam int FRAC_W = 4;	// counts up to nine fraction digits
	localparam int VALUE_W = 48;
	localparam int DIV_W = 30;	// 10^9 fits in 30 bits
	localparam int DIVIDEND_W = MANT_W + 16;
	localparam int DIV_CNT_W = $clog2(DIVIDEND_W + 1);

	localparam logic [7:0] START_RESET = 8'd60;
	localparam logic [7:0] END_RESET = 8'd62;
	localparam logic [7:0] CHAR_ZERO = 8'd48;
	localparam logic [7:0] CHAR_NINE = 8'd57;
	localparam logic [7:0] CHAR_POINT = 8'd46;

	localparam logic CFG_START = 1'b0;
	localparam logic CFG_END = 1'b1;

	typedef struct packed {
		logic sat;
		logic trunc;
		logic bad;
	} flags_t;

	typedef struct packed {
		logic [MANT_W-1:0] mant;
		logic [FRAC_W-1:0] frac;
		flags_t flags;
	} job_t;

	function automatic logic [DIV_W-1:0] pow10(input logic [FRAC_W-1:0] idx);
		logic [DIV_W-1:0] p;
		begin
			case (idx)
				4'd0: p = 30'd1;
				4'd1: p = 30'd10;
				4'd2: p = 30'd100;
				4'd3: p = 30'd1000;
				4'd4: p = 30'd10000;
				4'd5: p = 30'd100000;
				4'd6: p = 30'd1000000;
				4'd7: p = 30'd10000000;
				4'd8: p = 30'd100000000;
				default: p = 30'd1000000000;
			endcase
			return p;
		end
	endfunction

endpackage
`default_nettype wire

// ===== src/fadp_front.sv =====
// Front end: marker registers, frame tracking and digit accumulation.
// Pushes one job per closed frame. Depends on fadp_pkg.
`timescale 1ns / 1ps
`default_nettype none
module fadp_front #(
	parameter int MAX_CHARS = 63,
	parameter int MAX_FRAC_DIGITS = 6
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_valid,
	input wire logic cfg_index,
	input wire logic [7:0] cfg_data,
	input wire logic byte_valid,
	input wire logic [7:0] rx_byte,
	output fadp_pkg::job_t job,
	output logic job_push
);

	localparam int CNT_W = $clog2(MAX_CHARS + 1);

	logic [7:0] start_q, end_q;
	logic in_frame_q, point_q;
	logic [fadp_pkg::MANT_W-1:0] mant_q;
	logic [fadp_pkg::FRAC_W-1:0] frac_q;
	logic [CNT_W-1:0] count_q;
	fadp_pkg::flags_t flags_q;

	logic is_digit;
	logic [3:0] digit;
	logic [fadp_pkg::MANT_W+3:0] wide;
	logic [fadp_pkg::MANT_W+3:0] next_mant;

	assign is_digit = (rx_byte >= fadp_pkg::CHAR_ZERO) && (rx_byte <= fadp_pkg::CHAR_NINE);
	assign digit = 4'(rx_byte - fadp_pkg::CHAR_ZERO);
	assign wide = {4'b0, mant_q};
	// m*10 + d as two shifted adds; upper four bits flag overflow past 2^56-1
	assign next_mant = (wide << 3) + (wide << 1) + (fadp_pkg::MANT_W+4)'(digit);

	assign job_push = byte_valid && in_frame_q && (rx_byte == end_q);
	assign job.mant = mant_q;
	assign job.frac = frac_q;
	assign job.flags = flags_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= fadp_pkg::START_RESET;
			end_q <= fadp_pkg::END_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				fadp_pkg::CFG_START: start_q <= cfg_data;
				fadp_pkg::CFG_END: end_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q <= 1'b0;
			point_q <= 1'b0;
			mant_q <= '0;
			frac_q <= '0;
			count_q <= '0;
			flags_q <= '0;
		end else if (byte_valid) begin
			if (!in_frame_q || rx_byte == end_q) begin
				// open or close a frame: either way the frame state restarts
				if (!in_frame_q)
					in_frame_q <= (rx_byte == start_q);
				else
					in_frame_q <= 1'b0;
				point_q <= 1'b0;
				mant_q <= '0;
				frac_q <= '0;
				count_q <= '0;
				flags_q <= '0;
			end else if (count_q >= CNT_W'(MAX_CHARS)) begin
				flags_q.trunc <= 1'b1;
			end else begin
				count_q <= count_q + 1'b1;
				if (is_digit) begin
					if (point_q && frac_q >= fadp_pkg::FRAC_W'(MAX_FRAC_DIGITS)) begin
						flags_q.trunc <= 1'b1;
					end else begin
						if (next_mant[fadp_pkg::MANT_W+3:fadp_pkg::MANT_W] != 4'd0) begin
							mant_q <= '1;
							flags_q.sat <= 1'b1;
						end else begin
							mant_q <= next_mant[fadp_pkg::MANT_W-1:0];
						end
						if (point_q)
							frac_q <= frac_q + 1'b1;
					end
				end else if (rx_byte == fadp_pkg::CHAR_POINT && !point_q) begin
					point_q <= 1'b1;
				end else begin
					flags_q.bad <= 1'b1;
				end
			end
		end
	end

endmodule
`default_nettype wire

// ===== src/fadp_queue.sv =====
// Two-entry job queue between the front end and the divider.
// Depends on fadp_pkg for the job type.
`timescale 1ns / 1ps
`default_nettype none
module fadp_queue (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic push,
	input wire fadp_pkg::job_t push_job,
	input wire logic pop,
	output fadp_pkg::job_t pop_job,
	output logic full,
	output logic empty
);

	fadp_pkg::job_t slot_q [2];
	logic wr_ptr_q, rd_ptr_q;
	logic [1:0] count_q;

	assign full = (count_q == 2'd2);
	assign empty = (count_q == 2'd0);
	assign pop_job = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push && !full)
			slot_q[wr_ptr_q] <= push_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push && !full)
				wr_ptr_q <= ~wr_ptr_q;
			if (pop && !empty)
				rd_ptr_q <= ~rd_ptr_q;
			case ({push && !full, pop && !empty})
				2'b10: count_q <= count_q + 1'b1;
				2'b01: count_q <= count_q - 1'b1;
				default: ;
			endcase
		end
	end

endmodule
`default_nettype wire

// ===== src/fadp_back.sv =====
// Back end: bit-serial division of mantissa * 2^16 by 10^frac, saturation,
// and the output register. Depends on fadp_pkg.
`timescale 1ns / 1ps
`default_nettype none
module fadp_back (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic job_ready,
	input wire fadp_pkg::job_t job,
	output logic job_pop,
	output logic out_valid,
	input wire logic out_ready,
	output logic [fadp_pkg::VALUE_W-1:0] out_value,
	output logic [2:0] out_frac,
	output fadp_pkg::flags_t out_flags
);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_DIV = 3'b010,
		ST_HOLD = 3'b100
	} state_t;

	state_t state_q;
	logic [fadp_pkg::DIVIDEND_W-1:0] quo_q;	// dividend shifts out, quotient shifts in
	logic [fadp_pkg::DIV_W-1:0] rem_q, divisor_q;
	logic [fadp_pkg::DIV_CNT_W-1:0] cnt_q;
	logic [2:0] frac_q;
	fadp_pkg::flags_t flags_q;

	logic [fadp_pkg::DIV_W:0] trial;
	logic take;
	logic [fadp_pkg::DIV_W:0] diff;
	logic over;

	assign trial = {rem_q, quo_q[fadp_pkg::DIVIDEND_W-1]};
	assign take = trial >= {1'b0, divisor_q};
	assign diff = trial - {1'b0, divisor_q};
	assign over = quo_q[fadp_pkg::DIVIDEND_W-1:fadp_pkg::VALUE_W] != '0;
	assign job_pop = (state_q == ST_IDLE) && job_ready;

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				quo_q <= {job.mant, 16'd0};
				rem_q <= '0;
				divisor_q <= fadp_pkg::pow10(job.frac);
				frac_q <= job.frac[2:0];
				flags_q <= job.flags;
			end
			ST_DIV: begin
				quo_q <= {quo_q[fadp_pkg::DIVIDEND_W-2:0], take};
				rem_q <= take ? diff[fadp_pkg::DIV_W-1:0] : trial[fadp_pkg::DIV_W-1:0];
			end
			default: ;
		endcase
		if (state_q == ST_HOLD && (!out_valid || out_ready)) begin
			out_value <= over ? '1 : quo_q[fadp_pkg::VALUE_W-1:0];
			out_frac <= frac_q;
			out_flags.bad <= flags_q.bad;
			out_flags.trunc <= flags_q.trunc;
			out_flags.sat <= flags_q.sat | over;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q <= '0;
			out_valid <= 1'b0;
		end else begin
			if (state_q == ST_HOLD && (!out_valid || out_ready))
				out_valid <= 1'b1;
			else if (out_ready)
				out_valid <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (job_ready) begin
						state_q <= ST_DIV;
						cnt_q <= fadp_pkg::DIV_CNT_W'(fadp_pkg::DIVIDEND_W - 1);
					end
				end
				ST_DIV: begin
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == '0)
						state_q <= ST_HOLD;
				end
				ST_HOLD: begin
					if (!out_valid || out_ready)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

// ===== src/framed_ascii_decimal_parser.sv =====
// Top level of the framed ASCII decimal parser: front end, job queue, divider.
// Depends on fadp_pkg, fadp_front, fadp_queue and fadp_back.
//
//  channel | dir | handshake          | payload
//  s_      | in  | s_tvalid/s_tready  | s_tdata: rx_byte
//  m_      | out | m_tvalid/m_tready  | m_tdata: value_q16, frac_digits; m_tuser: flags
//  cfg_    | in  | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// Bytes are taken one per cycle. Input bytes are held off while the
// two-entry job queue is full; cfg writes are always taken. The divider works
// out one quotient bit per cycle over the 72-bit dividend, after a load step and before the hand-off.
// Reset returns the markers to '<' and '>' and drops any open frame.
// The output register lets the divider start the next frame while a result waits.
`timescale 1ns / 1ps
`default_nettype none
module framed_ascii_decimal_parser #(
	parameter int MAX_CHARS = 63,
	parameter int MAX_FRAC_DIGITS = 6
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic s_tvalid,
	output logic s_tready,
	input wire logic [7:0] s_tdata,	// [7:0] rx_byte
	output logic m_tvalid,
	input wire logic m_tready,
	output logic [55:0] m_tdata,	// [47:0] value_q16, [50:48] frac_digits, rest zero
	output logic [2:0] m_tuser,	// [0] bad_char, [1] truncated, [2] saturated
	input wire logic cfg_valid,
	output logic cfg_ready,
	input wire logic cfg_index,
	input wire logic [7:0] cfg_data
);

	fadp_pkg::job_t push_job, pop_job;
	logic job_push, job_pop, q_full, q_empty;
	logic [fadp_pkg::VALUE_W-1:0] value;
	logic [2:0] frac;
	fadp_pkg::flags_t flags;

	assign s_tready = !q_full;
	assign cfg_ready = 1'b1;
	assign m_tdata = {5'd0, frac, value};
	assign m_tuser = {flags.sat, flags.trunc, flags.bad};

	fadp_front #(
		.MAX_CHARS(MAX_CHARS),
		.MAX_FRAC_DIGITS(MAX_FRAC_DIGITS)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.byte_valid(s_tvalid && s_tready),
		.rx_byte(s_tdata),
		.job(push_job),
		.job_push(job_push)
	);

	fadp_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(job_push),
		.push_job(push_job),
		.pop(job_pop),
		.pop_job(pop_job),
		.full(q_full),
		.empty(q_empty)
	);

	fadp_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.job_ready(!q_empty),
		.job(pop_job),
		.job_pop(job_pop),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.out_value(value),
		.out_frac(frac),
		.out_flags(flags)
	);

endmodule
`default_nettype wire

// ===== bench/tb_framed_ascii_decimal_parser.sv =====
// Self-checking bench for framed_ascii_decimal_parser: random and directed byte
// frames, a built-in Q.16 predictor and an in-order result check.
// Depends on fadp_pkg and the RTL under src.
`timescale 1ns / 1ps
module tb_framed_ascii_decimal_parser;

	localparam int FRAME_MAX_CHARS = 63;
	localparam int FRAC_MAX = 6;
	localparam int HOLD_CYCLES = 600;
	localparam int DRAIN_CYCLES = 100;	// lets the divider finish its last frame
	localparam longint unsigned MANT_MAX = (64'd1 << 56) - 64'd1;
	localparam longint unsigned VAL_MAX = (64'd1 << 48) - 64'd1;

	typedef struct packed {
		logic [47:0] value;
		logic [2:0] frac;
		logic bad;
		logic trunc;
		logic sat;
	} reading_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [7:0] s_tdata = 8'd0;
	logic m_tvalid;
	logic m_tready;
	logic [55:0] m_tdata;
	logic [2:0] m_tuser;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic cfg_index = fadp_pkg::CFG_START;
	logic [7:0] cfg_data = 8'd0;

	// predictor state
	logic [7:0] start_mark = fadp_pkg::START_RESET;
	logic [7:0] end_mark = fadp_pkg::END_RESET;
	bit frame_open;
	longint unsigned mant_acc;
	bit point_got;
	int frac_n;
	int char_n;
	bit fl_bad, fl_trunc, fl_sat;

	reading_t want_q[$];
	int errors;
	int useful_n;	// bytes that reached the parser logic (not ignored)
	bit no_idle;
	bit hold_req;

	framed_ascii_decimal_parser #(
		.MAX_CHARS(FRAME_MAX_CHARS),
		.MAX_FRAC_DIGITS(FRAC_MAX)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	initial begin
		#5_000_000;
		$display("Test completed with failures");
		$finish;
	end

	function automatic longint unsigned ten_pow(input int k);
		longint unsigned p;
		p = 1;
		for (int i = 0; i < k; i++) p = p * 10;
		return p;
	endfunction

	function automatic reading_t to_q16();
		reading_t r;
		longint unsigned p, q, rem, v;
		logic sat;
		p = ten_pow(frac_n > 9 ? 9 : frac_n);
		q = mant_acc / p;
		rem = mant_acc % p;
		sat = fl_sat;
		if (q >= (64'd1 << 32)) begin
			v = VAL_MAX;
			sat = 1'b1;
		end else begin
			v = (q << 16) + ((rem << 16) / p);
			if (v > VAL_MAX) begin
				v = VAL_MAX;
				sat = 1'b1;
			end
		end
		r.value = v[47:0];
		r.frac = frac_n[2:0];
		r.bad = fl_bad;
		r.trunc = fl_trunc;
		r.sat = sat;
		return r;
	endfunction

	task automatic clear_frame();
		mant_acc = 0;
		point_got = 1'b0;
		frac_n = 0;
		char_n = 0;
		{fl_bad, fl_trunc, fl_sat} = 3'b000;
	endtask

	task automatic parse_rx_byte(input logic [7:0] b);
		longint unsigned d;
		if (!frame_open) begin
			if (b == start_mark) begin
				frame_open = 1'b1;
				clear_frame();
				useful_n++;
			end
			return;
		end
		useful_n++;
		if (b == end_mark) begin
			want_q.push_back(to_q16());
			frame_open = 1'b0;
			clear_frame();
			return;
		end
		// past the length limit a byte is dropped unclassified
		if (char_n >= FRAME_MAX_CHARS) begin
			fl_trunc = 1'b1;
			return;
		end
		char_n++;
		if (b >= fadp_pkg::CHAR_ZERO && b <= fadp_pkg::CHAR_NINE) begin
			d = 64'(b - fadp_pkg::CHAR_ZERO);
			if (point_got && frac_n >= FRAC_MAX) begin
				fl_trunc = 1'b1;
			end else begin
				if (mant_acc > (MANT_MAX - d) / 10) begin
					mant_acc = MANT_MAX;
					fl_sat = 1'b1;
				end else begin
					mant_acc = mant_acc * 10 + d;
				end
				if (point_got) frac_n++;
			end
		end else if (b == fadp_pkg::CHAR_POINT && !point_got) begin
			point_got = 1'b1;
		end else begin
			fl_bad = 1'b1;
		end
	endtask

	task automatic flag_mismatch(input string what, input longint unsigned got,
			input longint unsigned want);
		$display("MISMATCH %s: got 0x%0h, expected 0x%0h at %0t", what, got, want, $time);
		errors++;
	endtask

	// result check, in order
	always @(posedge clk) begin
		reading_t w;
		if (arst_n && m_tvalid && m_tready) begin
			if (want_q.size() == 0) begin
				flag_mismatch("unexpected result, value_q16", m_tdata[47:0], 0);
			end else begin
				w = want_q.pop_front();
				if (m_tdata[47:0] !== w.value)
					flag_mismatch("value_q16", m_tdata[47:0], w.value);
				if (m_tdata[50:48] !== w.frac)
					flag_mismatch("frac_digits", m_tdata[50:48], w.frac);
				if (m_tuser[0] !== w.bad)
					flag_mismatch("bad_char", m_tuser[0], w.bad);
				if (m_tuser[1] !== w.trunc)
					flag_mismatch("truncated", m_tuser[1], w.trunc);
				if (m_tuser[2] !== w.sat)
					flag_mismatch("saturated", m_tuser[2], w.sat);
			end
		end
	end

	// result side: random stalls, plus a long hold-off on request
	initial begin
		m_tready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				m_tready <= 1'b0;
				for (int n = 0; n < HOLD_CYCLES; n++) @(posedge clk);
			end
			m_tready <= no_idle || ($urandom_range(0, 99) >= 30);
		end
	end

	task automatic send_byte(input logic [7:0] b);
		while (!no_idle && $urandom_range(0, 99) < 30) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		do @(posedge clk); while (!s_tready);
		parse_rx_byte(b);
	endtask

	task automatic send_str(input string s);
		for (int i = 0; i < s.len(); i++) send_byte(s[i]);
	endtask

	// stop offering, wait for every pending result, then let the divider go quiet
	task automatic settle();
		s_tvalid <= 1'b0;
		while (want_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_markers(input logic [7:0] s, input logic [7:0] e);
		settle();
		for (int k = 0; k < 2; k++) begin
			cfg_valid <= 1'b1;
			cfg_index <= (k == 0) ? fadp_pkg::CFG_START : fadp_pkg::CFG_END;
			cfg_data <= (k == 0) ? s : e;
			do @(posedge clk); while (!cfg_ready);
			if (k == 0) start_mark = s;
			else end_mark = e;
		end
		cfg_valid <= 1'b0;
	endtask

	task automatic send_random_frame();
		int kind, len, pt_at;
		logic [7:0] b;
		kind = $urandom_range(0, 99);
		repeat ($urandom_range(0, 2)) send_byte(8'($urandom_range(0, 255)));
		if (kind < 70) len = $urandom_range(0, 12);
		else if (kind < 80) len = $urandom_range(14, 22);	// mantissa overflow
		else if (kind < 88) len = $urandom_range(58, 70);	// length limit
		else len = $urandom_range(0, 10);	// garbage frame
		pt_at = (kind < 70) ? $urandom_range(0, len) : $urandom_range(0, 2 * len);
		send_byte(start_mark);
		for (int i = 0; i < len; i++) begin
			if (kind >= 88) b = 8'($urandom_range(0, 255));
			else if (i == pt_at) b = fadp_pkg::CHAR_POINT;
			else if ($urandom_range(0, 99) < 4) b = 8'($urandom_range(0, 255));
			else if ($urandom_range(0, 99) < 3) b = fadp_pkg::CHAR_POINT;
			else b = fadp_pkg::CHAR_ZERO + 8'($urandom_range(0, 9));
			send_byte(b);
		end
		if (kind < 88 || $urandom_range(0, 1)) send_byte(end_mark);
	endtask

	task automatic test_random(input int n);
		int goal;
		goal = useful_n + n;
		while (useful_n < goal) send_random_frame();
	endtask

	task automatic test_directed();
		send_byte(8'h00);	// ignored outside a frame
		send_byte(8'hFF);
		send_str("<>");
		send_str("<.5>");
		send_str("<9.1234567>");	// seventh fraction digit dropped
		send_str("<a<1..>");	// bad byte, start marker in frame, second point
	endtask

	task automatic test_limits();
		send_byte(start_mark);
		repeat (20) send_byte(fadp_pkg::CHAR_ZERO + 8'($urandom_range(5, 9)));
		send_byte(end_mark);
		send_byte(start_mark);
		repeat (66) send_byte(fadp_pkg::CHAR_ZERO + 8'($urandom_range(0, 9)));
		send_byte(end_mark);
	endtask

	// fill the queue while results are held off, so the input stalls
	task automatic test_backpressure();
		settle();
		hold_req = 1'b1;
		repeat (20) begin
			send_byte(start_mark);
			send_byte(fadp_pkg::CHAR_ZERO + 8'($urandom_range(0, 9)));
			send_byte(end_mark);
		end
		settle();
	endtask

	task automatic test_markers();
		set_markers(8'h00, 8'hFF);
		test_random(100);
		set_markers(8'h7C, 8'h7C);	// same byte opens and closes
		test_random(100);
		set_markers(8'hFF, 8'h00);
		test_random(80);
		set_markers(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
		test_random(60);
		set_markers(fadp_pkg::START_RESET, fadp_pkg::END_RESET);
	endtask

	task automatic test_no_idle();
		no_idle = 1'b1;
		test_random(150);
		settle();
		no_idle = 1'b0;
	endtask

	initial begin
		clear_frame();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_limits();
		test_backpressure();
		test_markers();
		test_no_idle();
		test_random(100);
		settle();
		if (errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

// ===== filelist.f =====
src/fadp_pkg.sv
src/fadp_front.sv
src/fadp_queue.sv
src/fadp_back.sv
src/framed_ascii_decimal_parser.sv
bench/tb_framed_ascii_decimal_parser.sv
